@@ src/rdtq_pkg.sv @@
`default_nettype none
package rdtq_pkg;

  localparam int HANDLE_COUNT_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TIME_BITS_DEF    = 48;

  localparam int OP_W       = 3;
  localparam int HANDLE_W   = 4;
  localparam int DRAW_W     = 16;
  localparam int DELAY_W    = 16;
  localparam int COUNT_W    = 8;
  localparam int TIMEOUT_W  = 32;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 32'd0;
  localparam logic [DELAY_W-1:0]   BASE_RST    = 16'd100;
  localparam logic [DELAY_W-1:0]   CAP_RST     = 16'd1000;
  localparam logic [SHIFT_W-1:0]   SHIFT_RST   = 4'd4;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN    = 3'd0,
    OP_SCHEDULE = 3'd1,
    OP_POP      = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_RESET    = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT = 2'd0,
    REG_BASE    = 2'd1,
    REG_CAP     = 2'd2,
    REG_SHIFT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CH_HOLD   = 2'd0,
    CH_INSERT = 2'd1,
    CH_POP    = 2'd2,
    CH_CLEAR  = 2'd3
  } chain_cmd_t;

endpackage
`default_nettype wire

@@ src/rdtq_cell.sv @@
`default_nettype none
module rdtq_cell #(
  parameter int TIME_BITS = rdtq_pkg::TIME_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  rdtq_pkg::chain_cmd_t             cmd,
  input  wire [TIME_BITS-1:0]              ins_time,
  input  wire [rdtq_pkg::HANDLE_W-1:0]     ins_handle,
  input  wire                              left_keep,
  input  wire                              left_used,
  input  wire [TIME_BITS-1:0]              left_time,
  input  wire [rdtq_pkg::HANDLE_W-1:0]     left_handle,
  input  wire                              right_used,
  input  wire [TIME_BITS-1:0]              right_time,
  input  wire [rdtq_pkg::HANDLE_W-1:0]     right_handle,
  output logic                             used,
  output logic [TIME_BITS-1:0]             slot_time,
  output logic [rdtq_pkg::HANDLE_W-1:0]    slot_handle,
  output logic                             keep
);

  logic                          used_r, used_nxt;
  logic [TIME_BITS-1:0]          time_r, time_nxt;
  logic [rdtq_pkg::HANDLE_W-1:0] handle_r, handle_nxt;

  // entry stays put on insert when it is due no later than the new one
  assign keep = used_r && (time_r <= ins_time);

  always_comb begin
    used_nxt   = used_r;
    time_nxt   = time_r;
    handle_nxt = handle_r;
    case (cmd)
      rdtq_pkg::CH_INSERT: begin
        if (!keep) begin
          if (left_keep) begin
            used_nxt   = 1'b1;
            time_nxt   = ins_time;
            handle_nxt = ins_handle;
          end else begin
            used_nxt   = left_used;
            time_nxt   = left_time;
            handle_nxt = left_handle;
          end
        end
      end
      rdtq_pkg::CH_POP: begin
        used_nxt   = right_used;
        time_nxt   = right_time;
        handle_nxt = right_handle;
      end
      rdtq_pkg::CH_CLEAR: begin
        used_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
    time_r   <= time_nxt;
    handle_r <= handle_nxt;
  end

  assign used        = used_r;
  assign slot_time   = time_r;
  assign slot_handle = handle_r;

endmodule
`default_nettype wire

@@ src/rdtq_queue.sv @@
`default_nettype none
module rdtq_queue #(
  parameter int QUEUE_DEPTH = rdtq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = rdtq_pkg::TIME_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  rdtq_pkg::chain_cmd_t            cmd,
  input  wire [TIME_BITS-1:0]             ins_time,
  input  wire [rdtq_pkg::HANDLE_W-1:0]    ins_handle,
  output logic                            head_used,
  output logic [TIME_BITS-1:0]            head_time,
  output logic [rdtq_pkg::HANDLE_W-1:0]   head_handle,
  output logic                            full,
  output logic [QUEUE_DEPTH-1:0]          used_vec
);

  logic [QUEUE_DEPTH-1:0]        keep_vec;
  logic [TIME_BITS-1:0]          time_a   [QUEUE_DEPTH];
  logic [rdtq_pkg::HANDLE_W-1:0] handle_a [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    logic                          lk, lu, ru;
    logic [TIME_BITS-1:0]          lt, rt;
    logic [rdtq_pkg::HANDLE_W-1:0] lh, rh;

    if (i == 0) begin : g_first
      assign lk = 1'b1;
      assign lu = 1'b0;
      assign lt = '0;
      assign lh = '0;
    end else begin : g_mid_left
      assign lk = keep_vec[i-1];
      assign lu = used_vec[i-1];
      assign lt = time_a[i-1];
      assign lh = handle_a[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign ru = 1'b0;
      assign rt = '0;
      assign rh = '0;
    end else begin : g_mid_right
      assign ru = used_vec[i+1];
      assign rt = time_a[i+1];
      assign rh = handle_a[i+1];
    end

    rdtq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_slot (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .ins_time     (ins_time),
      .ins_handle   (ins_handle),
      .left_keep    (lk),
      .left_used    (lu),
      .left_time    (lt),
      .left_handle  (lh),
      .right_used   (ru),
      .right_time   (rt),
      .right_handle (rh),
      .used         (used_vec[i]),
      .slot_time    (time_a[i]),
      .slot_handle  (handle_a[i]),
      .keep         (keep_vec[i])
    );
  end

  assign head_used   = used_vec[0];
  assign head_time   = time_a[0];
  assign head_handle = handle_a[0];
  assign full        = used_vec[QUEUE_DEPTH-1];

endmodule
`default_nettype wire

@@ src/retry_deadline_timer_queue.sv @@
// sequence: an accepted start beat walks the calc, multiply, time-add and execute steps,
//   and out_valid is registered from the execute step. No new item is taken while the calc,
//   multiply, time-add and execute steps run; the next start may come in the strobe cycle
// reset: rst_n synchronous active low; empties the queue, clears all handles, config to defaults
// results cannot be stalled: out_valid is high for one cycle per item
`default_nettype none
module retry_deadline_timer_queue #(
  parameter int HANDLE_COUNT = rdtq_pkg::HANDLE_COUNT_DEF,
  parameter int QUEUE_DEPTH  = rdtq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS    = rdtq_pkg::TIME_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire [rdtq_pkg::OP_W-1:0]          in_operation,
  input  wire [rdtq_pkg::HANDLE_W-1:0]      in_handle,
  input  wire [TIME_BITS-1:0]               in_now,
  input  wire [rdtq_pkg::DRAW_W-1:0]        in_random_draw,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [rdtq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [rdtq_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  output logic                              out_attempt_allowed,
  output logic                              out_scheduled,
  output logic [rdtq_pkg::DELAY_W-1:0]      out_delay_out,
  output logic [rdtq_pkg::COUNT_W-1:0]      out_retry_number,
  output logic                              out_popped_valid,
  output logic [rdtq_pkg::HANDLE_W-1:0]     out_popped_handle,
  output logic                              out_queue_pending,
  output logic                              out_next_due_valid,
  output logic [TIME_BITS-1:0]              out_next_due_time,
  output logic                              out_queue_full_error,
  output logic                              out_retries_enabled
);

  localparam int HIDX_W  = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
  localparam int ARM_W   = ((TIME_BITS > rdtq_pkg::TIMEOUT_W) ? TIME_BITS
                                                            : rdtq_pkg::TIMEOUT_W) + 1;
  localparam int AT_W    = TIME_BITS + 1;
  localparam int CNT_W   = rdtq_pkg::COUNT_W;
  localparam int DLY_W   = rdtq_pkg::DELAY_W;
  localparam int SHW_W   = DLY_W + (1 << rdtq_pkg::SHIFT_W) - 1;
  localparam int PROD_W  = 2 * DLY_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_MUL, S_ADD, S_EXEC, S_OUT
  } state_t;

  state_t state_r;

  // config registers
  logic [rdtq_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [DLY_W-1:0]               base_r, cap_r;
  logic [rdtq_pkg::SHIFT_W-1:0]   shift_r;

  // captured item
  logic [rdtq_pkg::OP_W-1:0]      op_r;
  logic [rdtq_pkg::HANDLE_W-1:0]  handle_r;
  logic [HIDX_W-1:0]              hidx_r;
  logic                           hok_r;
  logic [TIME_BITS-1:0]           now_r;
  logic [rdtq_pkg::DRAW_W-1:0]    draw_r;

  // handle state
  logic [HANDLE_COUNT-1:0]        dv_r;
  logic [HANDLE_COUNT-1:0]        cnt_vld_r;
  logic [TIME_BITS-1:0]           dl_mem  [HANDLE_COUNT];
  logic [CNT_W-1:0]               cnt_mem [HANDLE_COUNT];
  logic [TIME_BITS-1:0]           dl_rd_r;
  logic [CNT_W-1:0]               cnt_rd_r;

  // datapath registers
  logic                           dv_cur_r, cnt_zero_r, in_win_r, at_lt_r;
  logic [CNT_W-1:0]               next_r;
  logic [DLY_W-1:0]               upper_r, delay_r;
  logic [TIME_BITS-1:0]           arm_dl_r, at_r;
  logic [PROD_W-1:0]              prod_r;

  // registered results
  logic                           allowed_r, sched_r, pop_v_r, full_err_r, out_valid_r;
  logic [DLY_W-1:0]               delay_o_r;
  logic [CNT_W-1:0]               retry_o_r;
  logic [rdtq_pkg::HANDLE_W-1:0]  pop_h_r;

  logic                           accept;
  logic [HIDX_W-1:0]              hidx_in;
  logic                           hok_in;

  assign busy      = (state_r != S_IDLE) && (state_r != S_OUT);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign hidx_in   = HIDX_W'(in_handle);
  assign hok_in    = 9'(in_handle) < 9'(HANDLE_COUNT);

  // chain
  rdtq_pkg::chain_cmd_t           ch_cmd;
  logic                           q_head_used, q_full;
  logic [TIME_BITS-1:0]           q_head_time;
  logic [rdtq_pkg::HANDLE_W-1:0]  q_head_handle;
  logic [QUEUE_DEPTH-1:0]         q_used_vec;

  rdtq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ch_cmd),
    .ins_time    (at_r),
    .ins_handle  (handle_r),
    .head_used   (q_head_used),
    .head_time   (q_head_time),
    .head_handle (q_head_handle),
    .full        (q_full),
    .used_vec    (q_used_vec)
  );

  // calc step
  logic [CNT_W-1:0]  cnt_cur, next_cnt, sh_raw;
  logic [rdtq_pkg::SHIFT_W-1:0] sh;
  logic [SHW_W-1:0]  shifted;
  logic [DLY_W-1:0]  upper;
  logic [ARM_W-1:0]  arm_sum;
  logic [TIME_BITS-1:0] arm_dl;

  always_comb begin
    cnt_cur  = cnt_vld_r[hidx_r] ? cnt_rd_r : '0;
    next_cnt = (cnt_cur == '1) ? cnt_cur : cnt_cur + CNT_W'(1);
    sh_raw   = next_cnt - CNT_W'(1);
    sh       = (sh_raw > CNT_W'(shift_r)) ? shift_r : rdtq_pkg::SHIFT_W'(sh_raw);
    shifted  = SHW_W'(base_r) << sh;
    upper    = (shifted > SHW_W'(cap_r)) ? cap_r : DLY_W'(shifted);
    arm_sum  = ARM_W'(now_r) + ARM_W'(timeout_r);
    arm_dl   = (|arm_sum[ARM_W-1:TIME_BITS]) ? '1 : arm_sum[TIME_BITS-1:0];
  end

  // add step
  logic [AT_W-1:0]      at_sum;
  logic [TIME_BITS-1:0] at_sat;
  logic [DLY_W-1:0]     delay;

  always_comb begin
    delay  = prod_r[PROD_W-1:DLY_W];
    at_sum = AT_W'(now_r) + AT_W'(delay);
    at_sat = at_sum[TIME_BITS] ? '1 : at_sum[TIME_BITS-1:0];
  end

  // execute step
  logic                 ex_armed, ex_allowed, ex_sched, ex_full, ex_pop;
  logic                 ex_dl_we, ex_cnt_we, ex_hreset;
  logic [TIME_BITS-1:0] ex_dl;

  always_comb begin
    ex_armed   = 1'b0;
    ex_allowed = 1'b0;
    ex_sched   = 1'b0;
    ex_full    = 1'b0;
    ex_pop     = 1'b0;
    ex_hreset  = 1'b0;
    ex_dl      = dl_rd_r;
    ch_cmd     = rdtq_pkg::CH_HOLD;
    if (state_r == S_EXEC) begin
      case (rdtq_pkg::op_t'(op_r))
        rdtq_pkg::OP_BEGIN: begin
          if (hok_r) begin
            ex_armed   = !dv_cur_r && (timeout_r != '0);
            ex_dl      = ex_armed ? arm_dl_r : dl_rd_r;
            ex_allowed = cnt_zero_r || ((dv_cur_r || ex_armed) && (now_r < ex_dl));
          end
        end
        rdtq_pkg::OP_SCHEDULE: begin
          if (hok_r && in_win_r && at_lt_r) begin
            if (q_full) begin
              ex_full = 1'b1;
            end else begin
              ex_sched = 1'b1;
              ch_cmd   = rdtq_pkg::CH_INSERT;
            end
          end
        end
        rdtq_pkg::OP_POP: begin
          if (q_head_used && (q_head_time <= now_r)) begin
            ex_pop = 1'b1;
            ch_cmd = rdtq_pkg::CH_POP;
          end
        end
        rdtq_pkg::OP_CLEAR: begin
          ch_cmd = rdtq_pkg::CH_CLEAR;
        end
        rdtq_pkg::OP_RESET: begin
          ex_hreset = hok_r;
        end
        default: begin
        end
      endcase
    end
    ex_dl_we  = ex_armed;
    ex_cnt_we = ex_sched;
  end

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= rdtq_pkg::TIMEOUT_RST;
      base_r    <= rdtq_pkg::BASE_RST;
      cap_r     <= rdtq_pkg::CAP_RST;
      shift_r   <= rdtq_pkg::SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (rdtq_pkg::cfg_reg_t'(cfg_index))
        rdtq_pkg::REG_TIMEOUT: timeout_r <= cfg_data;
        rdtq_pkg::REG_BASE:    base_r    <= cfg_data[DLY_W-1:0];
        rdtq_pkg::REG_CAP:     cap_r     <= cfg_data[DLY_W-1:0];
        rdtq_pkg::REG_SHIFT:   shift_r   <= cfg_data[rdtq_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // per-handle memories
  always_ff @(posedge clk) begin
    if (accept) begin
      dl_rd_r  <= dl_mem[hidx_in];
      cnt_rd_r <= cnt_mem[hidx_in];
    end
    if (ex_dl_we) begin
      dl_mem[hidx_r] <= arm_dl_r;
    end
    if (ex_cnt_we) begin
      cnt_mem[hidx_r] <= next_r;
    end
  end

  // per-handle flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r      <= '0;
      cnt_vld_r <= '0;
    end else begin
      if (ex_armed) begin
        dv_r[hidx_r] <= 1'b1;
      end
      if (ex_sched) begin
        cnt_vld_r[hidx_r] <= 1'b1;
      end
      if (ex_hreset) begin
        dv_r[hidx_r]      <= 1'b0;
        cnt_vld_r[hidx_r] <= 1'b0;
      end
    end
  end

  // sequencer, datapath and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_EXEC);
      case (state_r)
        S_IDLE, S_OUT: begin
          if (accept) begin
            state_r <= S_CALC;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CALC:  state_r <= S_MUL;
        S_MUL:   state_r <= S_ADD;
        S_ADD:   state_r <= S_EXEC;
        S_EXEC:  state_r <= S_OUT;
        default: state_r <= S_IDLE;
      endcase
    end

    if (accept) begin
      op_r     <= in_operation;
      handle_r <= in_handle;
      hidx_r   <= hidx_in;
      hok_r    <= hok_in;
      now_r    <= in_now;
      draw_r   <= in_random_draw;
    end
    if (state_r == S_CALC) begin
      dv_cur_r   <= dv_r[hidx_r];
      cnt_zero_r <= (cnt_cur == '0);
      in_win_r   <= dv_r[hidx_r] && (now_r < dl_rd_r);
      next_r     <= next_cnt;
      upper_r    <= upper;
      arm_dl_r   <= arm_dl;
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(draw_r) * PROD_W'({1'b0, upper_r} + (DLY_W + 1)'(1));
    end
    if (state_r == S_ADD) begin
      delay_r <= delay;
      at_r    <= at_sat;
      at_lt_r <= at_sat < dl_rd_r;
    end
    if (state_r == S_EXEC) begin
      allowed_r  <= ex_allowed;
      sched_r    <= ex_sched;
      delay_o_r  <= ex_sched ? delay_r : '0;
      retry_o_r  <= ex_sched ? next_r : '0;
      pop_v_r    <= ex_pop;
      pop_h_r    <= ex_pop ? q_head_handle : '0;
      full_err_r <= ex_full;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_attempt_allowed  = allowed_r;
  assign out_scheduled        = sched_r;
  assign out_delay_out        = delay_o_r;
  assign out_retry_number     = retry_o_r;
  assign out_popped_valid     = pop_v_r;
  assign out_popped_handle    = pop_h_r;
  assign out_queue_pending    = q_head_used;
  assign out_next_due_valid   = q_head_used;
  assign out_next_due_time    = q_head_used ? q_head_time : '0;
  assign out_queue_full_error = full_err_r;
  assign out_retries_enabled  = (timeout_r != '0);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  a_queue_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((q_used_vec >> 1) & ~q_used_vec) == '0)
    else $error("queue slots in use are not a prefix");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_queue_full_error) |-> (out_queue_pending && !out_scheduled))
    else $error("full refusal with an empty queue or a scheduled retry");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EXEC))
    else $error("result strobe without an execute step");

endmodule
`default_nettype wire
